@@ rtl/core/dmf_pkg.sv @@
// Shared types and constants for the Dinic max-flow core.
// Used by dmf_ctrl, dmf_datapath and dinic_max_flow_core.
`default_nettype none
package dmf_pkg;

    localparam int ACTION_W     = 2;
    localparam int NODE_FIELD_W = 6;
    localparam int CAP_FIELD_W  = 32;
    localparam int FLOW_W       = 40;
    localparam int NCOUNT_W     = 7;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 7;
    localparam int CMP_W        = 9;

    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SOLVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SINK   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NCOUNT = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE,
        S_ADD_A, S_ADD_B, S_ADD_C, S_ADD_D,
        S_BFS_INIT, S_BFS_POP, S_BFS_U, S_BFS_E0, S_BFS_EDGE, S_BFS_V,
        S_DFS_INIT, S_DFS_TOP, S_DFS_E, S_DFS_CHK, S_DFS_CHK2,
        S_DFS_BK0, S_DFS_BK1, S_DFS_BK2,
        S_AUG_M0, S_AUG_M1, S_AUG_M2,
        S_AUG_S0, S_AUG_S1, S_AUG_S2, S_AUG_S3,
        S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_DECODE,
        OP_ADD_A, OP_ADD_B, OP_ADD_C, OP_ADD_D,
        OP_BFS_INIT, OP_BFS_POP, OP_BFS_U, OP_BFS_E0, OP_BFS_EDGE, OP_BFS_V,
        OP_DFS_INIT, OP_DFS_TOP, OP_DFS_E, OP_DFS_CHK, OP_DFS_CHK2,
        OP_DFS_BK0, OP_DFS_BK1, OP_DFS_BK2,
        OP_AUG_M0, OP_AUG_M1, OP_AUG_M2,
        OP_AUG_S0, OP_AUG_S1, OP_AUG_S2, OP_AUG_S3
    } t_op;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                add_ok;
        logic                solve_ok;
        logic                queue_empty;
        logic                sink_reached;
        logic                edge_empty;
        logic                dfs_e_empty;
        logic                depth_zero;
        logic                at_sink;
        logic                last_idx;
    } t_dp_status;

endpackage
`default_nettype wire

@@ rtl/core/dinic_max_flow_core.sv @@
// Top level of the Dinic max-flow core: edge store plus solver.
// Depends on dmf_pkg, dmf_ctrl and dmf_datapath.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+---------------------------------------------
//   command   | start, busy                | i_action, i_edge_from, i_edge_to,
//             |                            | i_edge_capacity
//   result    | o_result_valid (strobe)    | o_flow_value, o_status
//   config    | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// A beat is taken when start is high and busy is low; one result beat follows per command.
// Add edge: decode, then the add steps ADD_A to ADD_D write the forward and reverse slots,
// then the strobe. Clear, a dropped add, an unknown action or a solve with bad terminals:
// decode, then the strobe. Solve is data dependent: it alternates a level pass (BFS from
// the source) with a path search that augments each path it finds, and strobes once a
// level pass no longer reaches the sink.
// Reset (synchronous, i_rst_n low) empties the store and loads the default registers.
// The result strobe lasts one cycle; the receiver cannot stall it.
`default_nettype none
module dinic_max_flow_core #(
    parameter int MAX_NODES  = 64,
    parameter int EDGE_SLOTS = 512,
    parameter int CAP_BITS   = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [dmf_pkg::ACTION_W-1:0]         i_action,
    input  logic [dmf_pkg::NODE_FIELD_W-1:0]     i_edge_from,
    input  logic [dmf_pkg::NODE_FIELD_W-1:0]     i_edge_to,
    input  logic [dmf_pkg::CAP_FIELD_W-1:0]      i_edge_capacity,
    output logic                                 o_result_valid,
    output logic [dmf_pkg::FLOW_W-1:0]           o_flow_value,
    output logic                                 o_status,
    input  logic                                 i_cfg_we,
    input  logic [dmf_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [dmf_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import dmf_pkg::*;

    t_op        op;
    t_dp_status dp_status;

    dmf_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_dp           (dp_status),
        .o_op           (op),
        .busy           (busy),
        .o_result_valid (o_result_valid)
    );

    dmf_datapath #(
        .MAX_NODES  (MAX_NODES),
        .EDGE_SLOTS (EDGE_SLOTS),
        .CAP_BITS   (CAP_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (op),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_action        (i_action),
        .i_edge_from     (i_edge_from),
        .i_edge_to       (i_edge_to),
        .i_edge_capacity (i_edge_capacity),
        .o_dp            (dp_status),
        .o_flow_value    (o_flow_value),
        .o_status        (o_status)
    );

endmodule
`default_nettype wire

@@ rtl/core/dmf_ctrl.sv @@
// Sequencer for the max-flow core: add, clear, level pass, path search, augment.
// Depends on dmf_pkg; drives dmf_datapath through t_op, reads t_dp_status.
`default_nettype none
module dmf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  dmf_pkg::t_dp_status i_dp,
    output dmf_pkg::t_op        o_op,
    output logic                busy,
    output logic                o_result_valid
);
    import dmf_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (start) n_state = S_DECODE;
            S_DECODE: begin
                if (i_dp.action == ACT_ADD) begin
                    n_state = i_dp.add_ok ? S_ADD_A : S_DONE;
                end else if (i_dp.action == ACT_SOLVE) begin
                    n_state = i_dp.solve_ok ? S_BFS_INIT : S_DONE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_ADD_A:    n_state = S_ADD_B;
            S_ADD_B:    n_state = S_ADD_C;
            S_ADD_C:    n_state = S_ADD_D;
            S_ADD_D:    n_state = S_DONE;
            S_BFS_INIT: n_state = S_BFS_POP;
            S_BFS_POP: begin
                if (i_dp.queue_empty) begin
                    n_state = i_dp.sink_reached ? S_DFS_INIT : S_DONE;
                end else begin
                    n_state = S_BFS_U;
                end
            end
            S_BFS_U:    n_state = S_BFS_E0;
            S_BFS_E0:   n_state = S_BFS_EDGE;
            S_BFS_EDGE: n_state = i_dp.edge_empty ? S_BFS_POP : S_BFS_V;
            S_BFS_V:    n_state = S_BFS_EDGE;
            S_DFS_INIT: n_state = S_DFS_TOP;
            S_DFS_TOP:  n_state = i_dp.at_sink ? S_AUG_M0 : S_DFS_E;
            S_DFS_E: begin
                if (i_dp.dfs_e_empty) begin
                    n_state = i_dp.depth_zero ? S_BFS_INIT : S_DFS_BK0;
                end else begin
                    n_state = S_DFS_CHK;
                end
            end
            S_DFS_CHK:  n_state = S_DFS_CHK2;
            S_DFS_CHK2: n_state = S_DFS_TOP;
            S_DFS_BK0:  n_state = S_DFS_BK1;
            S_DFS_BK1:  n_state = S_DFS_BK2;
            S_DFS_BK2:  n_state = S_DFS_TOP;
            S_AUG_M0:   n_state = S_AUG_M1;
            S_AUG_M1:   n_state = S_AUG_M2;
            S_AUG_M2:   n_state = i_dp.last_idx ? S_AUG_S0 : S_AUG_M1;
            S_AUG_S0:   n_state = S_AUG_S1;
            S_AUG_S1:   n_state = S_AUG_S2;
            S_AUG_S2:   n_state = S_AUG_S3;
            S_AUG_S3:   n_state = i_dp.last_idx ? S_DFS_TOP : S_AUG_S1;
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_op           = OP_NONE;
        busy           = (r_state != S_IDLE);
        o_result_valid = (r_state == S_DONE);
        case (r_state)
            S_IDLE:     o_op = start ? OP_LOAD : OP_NONE;
            S_DECODE:   o_op = OP_DECODE;
            S_ADD_A:    o_op = OP_ADD_A;
            S_ADD_B:    o_op = OP_ADD_B;
            S_ADD_C:    o_op = OP_ADD_C;
            S_ADD_D:    o_op = OP_ADD_D;
            S_BFS_INIT: o_op = OP_BFS_INIT;
            S_BFS_POP:  o_op = OP_BFS_POP;
            S_BFS_U:    o_op = OP_BFS_U;
            S_BFS_E0:   o_op = OP_BFS_E0;
            S_BFS_EDGE: o_op = OP_BFS_EDGE;
            S_BFS_V:    o_op = OP_BFS_V;
            S_DFS_INIT: o_op = OP_DFS_INIT;
            S_DFS_TOP:  o_op = OP_DFS_TOP;
            S_DFS_E:    o_op = OP_DFS_E;
            S_DFS_CHK:  o_op = OP_DFS_CHK;
            S_DFS_CHK2: o_op = OP_DFS_CHK2;
            S_DFS_BK0:  o_op = OP_DFS_BK0;
            S_DFS_BK1:  o_op = OP_DFS_BK1;
            S_DFS_BK2:  o_op = OP_DFS_BK2;
            S_AUG_M0:   o_op = OP_AUG_M0;
            S_AUG_M1:   o_op = OP_AUG_M1;
            S_AUG_M2:   o_op = OP_AUG_M2;
            S_AUG_S0:   o_op = OP_AUG_S0;
            S_AUG_S1:   o_op = OP_AUG_S1;
            S_AUG_S2:   o_op = OP_AUG_S2;
            S_AUG_S3:   o_op = OP_AUG_S3;
            default:    o_op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/core/dmf_datapath.sv @@
// Datapath of the max-flow core: edge and node memories, BFS queue, path stack.
// Depends on dmf_pkg; sequenced by dmf_ctrl.
`default_nettype none
module dmf_datapath #(
    parameter int MAX_NODES  = 64,
    parameter int EDGE_SLOTS = 512,
    parameter int CAP_BITS   = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  dmf_pkg::t_op                         i_op,
    input  logic                                 i_cfg_we,
    input  logic [dmf_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [dmf_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [dmf_pkg::ACTION_W-1:0]         i_action,
    input  logic [dmf_pkg::NODE_FIELD_W-1:0]     i_edge_from,
    input  logic [dmf_pkg::NODE_FIELD_W-1:0]     i_edge_to,
    input  logic [dmf_pkg::CAP_FIELD_W-1:0]      i_edge_capacity,
    output dmf_pkg::t_dp_status                  o_dp,
    output logic [dmf_pkg::FLOW_W-1:0]           o_flow_value,
    output logic                                 o_status
);
    import dmf_pkg::*;

    localparam int NB = $clog2(MAX_NODES);
    localparam int QW = $clog2(MAX_NODES + 1);
    localparam int LW = QW;
    localparam int SW = $clog2(EDGE_SLOTS);
    localparam int PW = $clog2(EDGE_SLOTS + 1);
    localparam int TW = ((CAP_BITS > FLOW_W) ? CAP_BITS : FLOW_W) + 1;
    localparam logic [PW-1:0]     EMPTY     = PW'(EDGE_SLOTS);
    localparam logic [63:0]       CAP_MAX64 = (64'd1 << CAP_BITS) - 64'd1;
    localparam logic [FLOW_W-1:0] FLOW_MAX  = {FLOW_W{1'b1}};

    // memories
    logic [CAP_BITS-1:0] m_cap  [EDGE_SLOTS];
    logic [NB-1:0]       m_head [EDGE_SLOTS];
    logic [PW-1:0]       m_next [EDGE_SLOTS];
    logic [PW-1:0]       m_lf   [MAX_NODES];
    logic [PW-1:0]       m_ll   [MAX_NODES];
    logic [LW-1:0]       m_lvl  [MAX_NODES];
    logic [PW-1:0]       m_rp   [MAX_NODES];
    logic [NB-1:0]       m_q    [MAX_NODES];
    logic [SW-1:0]       m_stk  [MAX_NODES];

    logic cap_we, head_we, next_we, lf_we, ll_we, lvl_we, rp_we, q_we, stk_we;
    logic [SW-1:0] cap_wa, cap_ra, head_wa, head_ra, next_wa, next_ra;
    logic [NB-1:0] lf_wa, lf_ra, ll_wa, ll_ra, lvl_wa, lvl_ra, rp_wa, rp_ra;
    logic [NB-1:0] q_wa, q_ra, stk_wa, stk_ra;
    logic [CAP_BITS-1:0] cap_wd, cap_rd;
    logic [NB-1:0]       head_wd, head_rd, q_wd, q_rd;
    logic [PW-1:0]       next_wd, next_rd, lf_wd, lf_rd, ll_wd, ll_rd, rp_wd, rp_rd;
    logic [LW-1:0]       lvl_wd, lvl_rd;
    logic [SW-1:0]       stk_wd, stk_rd;

    // control registers
    logic [PW-1:0]        r_slots, n_slots;
    logic [MAX_NODES-1:0] r_lf_v, n_lf_v, r_lvl_v, n_lvl_v, r_rp_v, n_rp_v;
    logic [NODE_FIELD_W-1:0] r_src, r_snk;
    logic [NCOUNT_W-1:0]     r_ncnt;

    // payload registers
    logic [ACTION_W-1:0] r_act, n_act;
    logic [NB-1:0]       r_from, n_from, r_to, n_to, r_u, n_u, r_v, n_v;
    logic [CAP_BITS-1:0] r_cap, n_cap, r_c, n_c, r_m, n_m;
    logic                r_add_ok, n_add_ok, r_status, n_status;
    logic [PW-1:0]       r_e, n_e, r_nxt, n_nxt;
    logic [LW-1:0]       r_lu, n_lu;
    logic [QW-1:0]       r_head, n_head, r_tail, n_tail, r_depth, n_depth, r_i, n_i;
    logic [SW-1:0]       r_s, n_s;
    logic [FLOW_W-1:0]   r_total, n_total;

    // derived values
    logic [CMP_W-1:0]    n_eff;
    logic                solve_ok, bfs_take, dfs_push, dfs_e_empty;
    logic [PW-1:0]       dfs_e;
    logic [SW-1:0]       fwd, rev, s_pair;
    logic [CAP_BITS-1:0] cap_sat;
    logic [TW-1:0]       tsum;
    logic [63:0]         cap_wide;
    logic [NB-1:0]       src_n, snk_n;

    always_comb begin
        n_eff = ({2'b0, r_ncnt} > CMP_W'(MAX_NODES)) ? CMP_W'(MAX_NODES) : {2'b0, r_ncnt};
        src_n = NB'(r_src);
        snk_n = NB'(r_snk);
        solve_ok = (CMP_W'(r_src) < n_eff) && (CMP_W'(r_snk) < n_eff) && (r_src != r_snk);
        fwd    = r_slots[SW-1:0];
        rev    = {fwd[SW-1:1], 1'b1};
        s_pair = {r_s[SW-1:1], ~r_s[0]};
        cap_wide = {32'b0, i_edge_capacity};
        cap_sat  = (cap_wide > CAP_MAX64) ? CAP_BITS'(CAP_MAX64) : CAP_BITS'(cap_wide);
        tsum   = TW'(r_total) + TW'(r_m);
        dfs_e  = r_rp_v[r_u] ? rp_rd : (r_lf_v[r_u] ? lf_rd : EMPTY);
        dfs_e_empty = (dfs_e == EMPTY);
        bfs_take = (CMP_W'(head_rd) < n_eff) && !r_lvl_v[head_rd] && (cap_rd != '0)
                   && (r_tail < QW'(MAX_NODES));
        dfs_push = (r_c != '0) && (CMP_W'(r_v) < n_eff) && r_lvl_v[r_v]
                   && (lvl_rd == r_lu + LW'(1)) && (r_depth < QW'(MAX_NODES));
    end

    always_comb begin
        o_dp.action       = r_act;
        o_dp.add_ok       = r_add_ok;
        o_dp.solve_ok     = solve_ok;
        o_dp.queue_empty  = (r_head == r_tail);
        o_dp.sink_reached = r_lvl_v[snk_n];
        o_dp.edge_empty   = (r_e == EMPTY);
        o_dp.dfs_e_empty  = dfs_e_empty;
        o_dp.depth_zero   = (r_depth == '0);
        o_dp.at_sink      = (r_u == snk_n);
        o_dp.last_idx     = ((r_i + QW'(1)) == r_depth);
    end

    always_comb begin
        cap_we = 1'b0;  cap_wa = fwd;   cap_wd = r_cap;  cap_ra = r_e[SW-1:0];
        head_we = 1'b0; head_wa = fwd;  head_wd = r_to;  head_ra = r_e[SW-1:0];
        next_we = 1'b0; next_wa = fwd;  next_wd = EMPTY; next_ra = r_e[SW-1:0];
        lf_we = 1'b0;   lf_wa = r_from; lf_wd = PW'(fwd); lf_ra = r_u;
        ll_we = 1'b0;   ll_wa = r_from; ll_wd = PW'(fwd); ll_ra = r_from;
        lvl_we = 1'b0;  lvl_wa = src_n; lvl_wd = '0;      lvl_ra = r_u;
        rp_we = 1'b0;   rp_wa = r_u;    rp_wd = r_nxt;    rp_ra = r_u;
        q_we = 1'b0;    q_wa = r_tail[NB-1:0]; q_wd = head_rd; q_ra = r_head[NB-1:0];
        stk_we = 1'b0;  stk_wa = r_depth[NB-1:0]; stk_wd = r_e[SW-1:0];
        stk_ra = r_i[NB-1:0];

        n_slots = r_slots; n_lf_v = r_lf_v; n_lvl_v = r_lvl_v; n_rp_v = r_rp_v;
        n_act = r_act; n_from = r_from; n_to = r_to; n_cap = r_cap;
        n_add_ok = r_add_ok; n_status = r_status;
        n_u = r_u; n_v = r_v; n_c = r_c; n_m = r_m; n_e = r_e; n_nxt = r_nxt;
        n_lu = r_lu; n_head = r_head; n_tail = r_tail; n_depth = r_depth; n_i = r_i;
        n_s = r_s; n_total = r_total;

        case (i_op)
            OP_LOAD: begin
                n_act  = i_action;
                n_from = NB'(i_edge_from);
                n_to   = NB'(i_edge_to);
                n_cap  = cap_sat;
                n_add_ok = (CMP_W'(i_edge_from) < CMP_W'(MAX_NODES))
                        && (CMP_W'(i_edge_to) < CMP_W'(MAX_NODES))
                        && ((32'(r_slots) + 32'd2) <= 32'(EDGE_SLOTS));
            end
            OP_DECODE: begin
                n_total  = '0;
                n_status = (r_act == ACT_ADD) && !r_add_ok;
                if (r_act == ACT_CLEAR) begin
                    n_lf_v  = '0;
                    n_slots = '0;
                end
            end
            OP_ADD_A: begin
                cap_we = 1'b1; head_we = 1'b1; next_we = 1'b1;
                ll_ra  = r_from;
            end
            OP_ADD_B: begin
                cap_we = 1'b1;  cap_wa = rev;  cap_wd = '0;
                head_we = 1'b1; head_wa = rev; head_wd = r_from;
                if (r_lf_v[r_from]) begin
                    next_we = 1'b1; next_wa = ll_rd[SW-1:0]; next_wd = PW'(fwd);
                end else begin
                    lf_we = 1'b1;
                    n_lf_v[r_from] = 1'b1;
                end
                ll_we = 1'b1;
            end
            OP_ADD_C: begin
                next_we = 1'b1; next_wa = rev; next_wd = EMPTY;
                ll_ra = r_to;
            end
            OP_ADD_D: begin
                if (r_lf_v[r_to]) begin
                    next_we = 1'b1; next_wa = ll_rd[SW-1:0]; next_wd = PW'(rev);
                end else begin
                    lf_we = 1'b1; lf_wa = r_to; lf_wd = PW'(rev);
                    n_lf_v[r_to] = 1'b1;
                end
                ll_we = 1'b1; ll_wa = r_to; ll_wd = PW'(rev);
                n_slots = r_slots + PW'(2);
            end
            OP_BFS_INIT: begin
                n_lvl_v = '0;
                n_lvl_v[src_n] = 1'b1;
                lvl_we = 1'b1;
                q_we = 1'b1; q_wa = '0; q_wd = src_n;
                n_head = '0;
                n_tail = QW'(1);
            end
            OP_BFS_POP: begin
                if (r_head != r_tail) n_head = r_head + QW'(1);
            end
            OP_BFS_U: begin
                n_u    = q_rd;
                lf_ra  = q_rd;
                lvl_ra = q_rd;
            end
            OP_BFS_E0: begin
                n_e  = r_lf_v[r_u] ? lf_rd : EMPTY;
                n_lu = lvl_rd;
            end
            OP_BFS_EDGE: begin
                // slot reads issued at r_e by default
            end
            OP_BFS_V: begin
                if (bfs_take) begin
                    lvl_we = 1'b1; lvl_wa = head_rd; lvl_wd = r_lu + LW'(1);
                    n_lvl_v[head_rd] = 1'b1;
                    q_we = 1'b1;
                    n_tail = r_tail + QW'(1);
                end
                n_e = next_rd;
            end
            OP_DFS_INIT: begin
                n_rp_v  = '0;
                n_u     = src_n;
                n_depth = '0;
            end
            OP_DFS_TOP: begin
                // resume, list head and level of r_u read by default
            end
            OP_DFS_E: begin
                n_e  = dfs_e;
                n_lu = lvl_rd;
                cap_ra = dfs_e[SW-1:0]; head_ra = dfs_e[SW-1:0]; next_ra = dfs_e[SW-1:0];
            end
            OP_DFS_CHK: begin
                n_v = head_rd; n_c = cap_rd; n_nxt = next_rd;
                lvl_ra = head_rd;
            end
            OP_DFS_CHK2: begin
                if (dfs_push) begin
                    stk_we  = 1'b1;
                    n_depth = r_depth + QW'(1);
                    n_u     = r_v;
                end else begin
                    rp_we = 1'b1;
                    n_rp_v[r_u] = 1'b1;
                end
            end
            OP_DFS_BK0: begin
                n_depth = r_depth - QW'(1);
                stk_ra  = n_depth[NB-1:0];
            end
            OP_DFS_BK1: begin
                n_s     = stk_rd;
                head_ra = {stk_rd[SW-1:1], ~stk_rd[0]};
                next_ra = stk_rd;
            end
            OP_DFS_BK2: begin
                // the edge taken from the tail node is exhausted; step past it
                n_u = head_rd;
                rp_we = 1'b1; rp_wa = head_rd; rp_wd = next_rd;
                n_rp_v[head_rd] = 1'b1;
            end
            OP_AUG_M0: begin
                n_i = '0; stk_ra = '0;
            end
            OP_AUG_M1: begin
                cap_ra = stk_rd;
            end
            OP_AUG_M2: begin
                if ((r_i == '0) || (cap_rd < r_m)) n_m = cap_rd;
                n_i = r_i + QW'(1);
                stk_ra = n_i[NB-1:0];
            end
            OP_AUG_S0: begin
                n_i = '0; stk_ra = '0;
            end
            OP_AUG_S1: begin
                n_s = stk_rd; cap_ra = stk_rd;
            end
            OP_AUG_S2: begin
                cap_we = 1'b1; cap_wa = r_s; cap_wd = cap_rd - r_m;
                cap_ra = s_pair;
            end
            OP_AUG_S3: begin
                cap_we = 1'b1; cap_wa = s_pair; cap_wd = cap_rd + r_m;
                n_i = r_i + QW'(1);
                stk_ra = n_i[NB-1:0];
                if ((r_i + QW'(1)) == r_depth) begin
                    n_total = (tsum > TW'(FLOW_MAX)) ? FLOW_MAX : FLOW_W'(tsum);
                    n_u     = src_n;
                    n_depth = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cap_we) m_cap[cap_wa] <= cap_wd;
        cap_rd <= m_cap[cap_ra];
        if (head_we) m_head[head_wa] <= head_wd;
        head_rd <= m_head[head_ra];
        if (next_we) m_next[next_wa] <= next_wd;
        next_rd <= m_next[next_ra];
        if (lf_we) m_lf[lf_wa] <= lf_wd;
        lf_rd <= m_lf[lf_ra];
        if (ll_we) m_ll[ll_wa] <= ll_wd;
        ll_rd <= m_ll[ll_ra];
        if (lvl_we) m_lvl[lvl_wa] <= lvl_wd;
        lvl_rd <= m_lvl[lvl_ra];
        if (rp_we) m_rp[rp_wa] <= rp_wd;
        rp_rd <= m_rp[rp_ra];
        if (q_we) m_q[q_wa] <= q_wd;
        q_rd <= m_q[q_ra];
        if (stk_we) m_stk[stk_wa] <= stk_wd;
        stk_rd <= m_stk[stk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= '0;
            r_lf_v  <= '0;
            r_lvl_v <= '0;
            r_rp_v  <= '0;
            r_src   <= NODE_FIELD_W'(0);
            r_snk   <= NODE_FIELD_W'(1);
            r_ncnt  <= NCOUNT_W'(64);
        end else begin
            r_slots <= n_slots;
            r_lf_v  <= n_lf_v;
            r_lvl_v <= n_lvl_v;
            r_rp_v  <= n_rp_v;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SOURCE: r_src  <= i_cfg_data[NODE_FIELD_W-1:0];
                    CFG_SINK:   r_snk  <= i_cfg_data[NODE_FIELD_W-1:0];
                    CFG_NCOUNT: r_ncnt <= i_cfg_data[NCOUNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act <= n_act; r_from <= n_from; r_to <= n_to; r_cap <= n_cap;
        r_add_ok <= n_add_ok; r_status <= n_status;
        r_u <= n_u; r_v <= n_v; r_c <= n_c; r_m <= n_m; r_e <= n_e; r_nxt <= n_nxt;
        r_lu <= n_lu; r_head <= n_head; r_tail <= n_tail; r_depth <= n_depth;
        r_i <= n_i; r_s <= n_s; r_total <= n_total;
    end

    assign o_flow_value = r_total;
    assign o_status     = r_status;

endmodule
`default_nettype wire
